@@ rtl/fpfa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared types and constants of the fixed partition fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

   localparam int DEF_MAX_BLOCKS = 16;
   localparam int DEF_SIZE_BITS  = 16;

   localparam int FIELD_INDEX_W  = 4;
   localparam int FIELD_SIZE_W   = 16;
   localparam int FIELD_STATUS_W = 2;
   localparam int CSR_DATA_W     = 5;
   localparam int CSR_COUNT_W    = 5;

   localparam logic       CSR_FIT_POLICY  = 1'b0;
   localparam logic       CSR_BLOCK_COUNT = 1'b1;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic       MODE_LOAD    = 1'b0;
   localparam logic       MODE_REQUEST = 1'b1;

   localparam logic [1:0] STATUS_LOADED = 2'd0;
   localparam logic [1:0] STATUS_ALLOC  = 2'd1;
   localparam logic [1:0] STATUS_NOFIT  = 2'd2;
   localparam logic [1:0] STATUS_RANGE  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic valid;
      logic found;
   } scan_flags_type;

endpackage

@@ rtl/fpfa_cell.sv @@
// ----------------------------------------------------------------------------
// fpfa_cell
// One partition slot: holds its size and used mark, and refines the scan
// candidate that passes through it on its way down the chain.
// ----------------------------------------------------------------------------
module fpfa_cell
   import fpfa_pkg::*;
#(
   parameter int INDEX     = 0,
   parameter int IDX_W     = 4,
   parameter int LIVE_W    = 5,
   parameter int SIZE_BITS = DEF_SIZE_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               fit_policy,
   input  logic [LIVE_W-1:0]        live_count,
   input  logic                     ld_we,
   input  logic [FIELD_INDEX_W-1:0] ld_idx,
   input  logic [SIZE_BITS-1:0]     ld_size,
   input  logic                     mk_we,
   input  logic [IDX_W-1:0]         mk_idx,
   input  scan_flags_type           flags_i,
   input  logic [SIZE_BITS-1:0]     req_i,
   input  logic [IDX_W-1:0]         best_idx_i,
   input  logic [SIZE_BITS-1:0]     best_size_i,
   output scan_flags_type           flags_o,
   output logic [SIZE_BITS-1:0]     req_o,
   output logic [IDX_W-1:0]         best_idx_o,
   output logic [SIZE_BITS-1:0]     best_size_o
);

   logic [SIZE_BITS-1:0] size_ff;
   logic                 used_ff;
   scan_flags_type       flags_ff, flags_in;
   logic [SIZE_BITS-1:0] req_ff;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [SIZE_BITS-1:0] best_size_ff, best_size_in;
   logic                 ld_hit, mk_hit, fits, take;

   assign ld_hit = ld_we && (LIVE_W'(ld_idx) == LIVE_W'(INDEX));
   assign mk_hit = mk_we && (mk_idx == IDX_W'(INDEX));

   always_comb begin
      fits = (LIVE_W'(INDEX) < live_count) && !used_ff && (size_ff >= req_i);
      take = fits && (!flags_i.found
                      || ((fit_policy == FIT_BEST)  && (size_ff < best_size_i))
                      || ((fit_policy == FIT_WORST) && (size_ff > best_size_i)));
      flags_in.valid = flags_i.valid;
      flags_in.found = flags_i.found || fits;
      best_idx_in    = take ? IDX_W'(INDEX) : best_idx_i;
      best_size_in   = take ? size_ff : best_size_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= '0;
         used_ff  <= 1'b0;
         flags_ff <= '0;
      end else begin
         if (ld_hit) begin
            size_ff <= ld_size;
            used_ff <= 1'b0;
         end else if (mk_hit) begin
            used_ff <= 1'b1;
         end
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_i;
      best_idx_ff  <= best_idx_in;
      best_size_ff <= best_size_in;
   end

   assign flags_o     = flags_ff;
   assign req_o       = req_ff;
   assign best_idx_o  = best_idx_ff;
   assign best_size_o = best_size_ff;

endmodule

@@ rtl/fixed_partition_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// Fixed partition table with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
// Each partition lives in one cell of a chain of MAX_BLOCKS cells. A request
// walks the chain one cell per clock: it is accepted and enters the chain,
// passes through every cell, and then the winner is marked and the result
// is staged; it moves to the output register once that register is free.
// An in-range load writes its cell on acceptance and then stages its status.
// Items are handled one at a time; a finished result waits in its own output
// register, so the next transaction can be accepted before it is taken.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator
   import fpfa_pkg::*;
#(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
   parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,  // block_index, size_value, zero pad
   input  logic                  req_tuser,  // mode
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,  // chosen_block, zero pad
   output logic [1:0]            rsp_tuser,  // status
   output logic                  rsp_tlast
);

   localparam int IDX_W   = $clog2(MAX_BLOCKS);
   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
   localparam int LIVE_W  = (CNT_W > CSR_COUNT_W) ? CNT_W : CSR_COUNT_W;

   logic [1:0]             policy_ff;
   logic [CSR_COUNT_W-1:0] count_ff;
   logic [LIVE_W-1:0]      live_count;

   state_type              state_ff, state_in;
   logic [1:0]             res_status_ff, res_status_in;
   logic [FIELD_INDEX_W-1:0] res_chosen_ff, res_chosen_in;
   logic                   res_last_ff, res_last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff;
   logic [FIELD_INDEX_W-1:0] rsp_chosen_ff;
   logic                   rsp_last_ff;
   logic                   rsp_load;

   logic                   accept, launch, ld_we, mk_we, in_range;
   logic [FIELD_INDEX_W-1:0] in_index;
   logic [SIZE_BITS-1:0]   in_size;

   scan_flags_type         flags [MAX_BLOCKS+1];
   logic [SIZE_BITS-1:0]   req_sz [MAX_BLOCKS+1];
   logic [IDX_W-1:0]       best_idx [MAX_BLOCKS+1];
   logic [SIZE_BITS-1:0]   best_size [MAX_BLOCKS+1];

   assign in_index = req_tdata[FIELD_INDEX_W-1:0];
   assign in_size  = SIZE_BITS'(req_tdata[FIELD_INDEX_W +: FIELD_SIZE_W]);

   assign live_count = (LIVE_W'(count_ff) > LIVE_W'(MAX_BLOCKS))
                       ? LIVE_W'(MAX_BLOCKS) : LIVE_W'(count_ff);
   assign in_range   = LIVE_W'(in_index) < live_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= FIT_FIRST;
         count_ff  <= CSR_COUNT_W'(16);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FIT_POLICY:  policy_ff <= csr_wdata[1:0];
            CSR_BLOCK_COUNT: count_ff  <= csr_wdata[CSR_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign flags[0].valid = launch;
   assign flags[0].found = 1'b0;
   assign req_sz[0]      = in_size;
   assign best_idx[0]    = '0;
   assign best_size[0]   = '0;

   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      fpfa_cell #(
         .INDEX     (i),
         .IDX_W     (IDX_W),
         .LIVE_W    (LIVE_W),
         .SIZE_BITS (SIZE_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .fit_policy  (policy_ff),
         .live_count  (live_count),
         .ld_we       (ld_we),
         .ld_idx      (in_index),
         .ld_size     (in_size),
         .mk_we       (mk_we),
         .mk_idx      (best_idx[MAX_BLOCKS]),
         .flags_i     (flags[i]),
         .req_i       (req_sz[i]),
         .best_idx_i  (best_idx[i]),
         .best_size_i (best_size[i]),
         .flags_o     (flags[i+1]),
         .req_o       (req_sz[i+1]),
         .best_idx_o  (best_idx[i+1]),
         .best_size_o (best_size[i+1])
      );
   end

   always_comb begin
      state_in      = state_ff;
      res_status_in = res_status_ff;
      res_chosen_in = res_chosen_ff;
      res_last_in   = res_last_ff;
      req_tready    = 1'b0;
      accept        = 1'b0;
      launch        = 1'b0;
      ld_we         = 1'b0;
      mk_we         = 1'b0;
      rsp_load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            if (accept) begin
               res_last_in   = req_tlast;
               res_chosen_in = '0;
               if (req_tuser == MODE_LOAD) begin
                  ld_we         = in_range;
                  res_status_in = in_range ? STATUS_LOADED : STATUS_RANGE;
                  state_in      = ST_DONE;
               end else begin
                  launch   = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (flags[MAX_BLOCKS].valid) begin
               mk_we = flags[MAX_BLOCKS].found;
               if (flags[MAX_BLOCKS].found) begin
                  res_status_in = STATUS_ALLOC;
                  res_chosen_in = FIELD_INDEX_W'(best_idx[MAX_BLOCKS]);
               end else begin
                  res_status_in = STATUS_NOFIT;
                  res_chosen_in = '0;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_chosen_ff <= res_chosen_in;
      res_last_ff   <= res_last_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_chosen_ff <= res_chosen_ff;
         rsp_last_ff   <= res_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_chosen_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
